### rtl/audio_log_fade_out_defines.svh
// Assertion macros for the fade block checkers.
`ifndef AUDIO_LOG_FADE_OUT_DEFINES_SVH
`define AUDIO_LOG_FADE_OUT_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define ALF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: check failed");

// Clocked assertion that also holds during reset.
`define ALF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("%m: check failed");

`endif

### rtl/alf_pkg.sv
package alf_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SKIP_W      = 16;
  localparam int REQ_W       = 2;
  localparam int POS_W       = 32;
  localparam int STEP_W      = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam int BLOCK_SHIFT = 9;                    // 512 positions per gain block
  localparam int FRAC_BITS   = 14;
  localparam int KW          = POS_W - BLOCK_SHIFT;  // block index width
  localparam int QW          = KW + FRAC_BITS;       // divider dividend width
  localparam int GW          = FRAC_BITS + 1;        // gain width
  localparam int SHIFT_W     = 4;
  localparam int DEEP_SHIFT  = 15;
  localparam int CNT_W       = $clog2(QW + 1);

  localparam logic [GW-1:0] UNITY_GAIN = GW'(1) << FRAC_BITS;

  localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SKIP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

  localparam logic [POS_W-1:0]  START_RST = 32'd15876000;
  localparam logic [STEP_W-1:0] STEP_RST  = 16'd215;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_step;
    logic gain_load;
    logic out_load;
  } alf_cmd_t;

  typedef struct packed {
    logic fade;
    logic hit;
    logic div_last;
    logic out_free;
  } alf_sts_t;

endpackage

### rtl/alf_in_if.sv
interface alf_in_if;
  logic                                valid;
  logic                                ready;
  logic [alf_pkg::REQ_W-1:0]           req_type;
  logic signed [alf_pkg::SAMPLE_W-1:0] sample_in;
  logic [alf_pkg::SKIP_W-1:0]          skip_count;

  modport source (output valid, req_type, sample_in, skip_count, input ready);
  modport sink (input valid, req_type, sample_in, skip_count, output ready);
endinterface

### rtl/alf_out_if.sv
interface alf_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [alf_pkg::SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

### rtl/audio_log_fade_out.sv
// Sample word: goes to the output register once that is free, if the gain block is
// cached or no fade applies. A new gain block first runs a 37-step restoring divider
// plus gain load. Skip and restart words end on accept; one word is in work at a time.
// The output register frees the input side while a result waits.
// Reset: position 0, no cached gain, enable 1, start 15876000, step 215.
module audio_log_fade_out (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  alf_in_if.sink                              in_if,
  alf_out_if.source                           out_if,
  input  logic                                cfg_we_i,
  input  logic [alf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [alf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import alf_pkg::*;

  alf_cmd_t cmd;
  alf_sts_t sts;

  alf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_sample_i (in_if.req_type == REQ_SAMPLE),
    .in_ready_o  (in_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  alf_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (in_if.req_type),
    .sample_in_i  (in_if.sample_in),
    .skip_count_i (in_if.skip_count),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .sample_out_o (out_if.sample_out)
  );

endmodule

### rtl/alf_ctrl.sv
module alf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_sample_i,
  output logic              in_ready_o,
  input  alf_pkg::alf_sts_t sts_i,
  output alf_pkg::alf_cmd_t cmd_o
);
  import alf_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_GAIN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_sample_i) begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (!sts_i.fade || sts_i.hit) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.gain_load = 1'b1;
        state_d         = S_CHECK;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/alf_dp.sv
module alf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  alf_pkg::alf_cmd_t                    cmd_i,
  output alf_pkg::alf_sts_t                    sts_o,
  input  logic [alf_pkg::REQ_W-1:0]            req_type_i,
  input  logic signed [alf_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic [alf_pkg::SKIP_W-1:0]           skip_count_i,
  input  logic                                 cfg_we_i,
  input  logic [alf_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [alf_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [alf_pkg::SAMPLE_W-1:0]  sample_out_o
);
  import alf_pkg::*;

  // configuration
  logic              en_q;
  logic [POS_W-1:0]  start_q;
  logic [STEP_W-1:0] step_q;
  logic [STEP_W-1:0] step_eff;

  // position and accepted sample
  logic [POS_W-1:0]           pos_q;
  logic [POS_W-1:0]           diff;
  logic signed [SAMPLE_W-1:0] smp_q;
  logic                       fade_q;
  logic [KW-1:0]              k_q;

  // cached gain
  logic          gvalid_q;
  logic [KW-1:0] gk_q;
  logic [GW-1:0] gain_q, gain_d;

  // divider: {k, 0^FRAC} / step gives s in the upper bits and f in the lower
  logic [QW-1:0]     q_q;
  logic [STEP_W-1:0] rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [STEP_W:0]   rem_sh;
  logic              ge;

  logic [KW-1:0]        shift_s;
  logic [FRAC_BITS-1:0] frac_f;
  logic [GW-1:0]        g_lin;

  logic [GW-1:0]                  gain_sel;
  logic signed [SAMPLE_W+GW:0]    prod;
  logic                           out_valid_q;
  logic signed [SAMPLE_W-1:0]     out_q;

  assign step_eff = (step_q == '0) ? STEP_W'(1) : step_q;
  assign diff     = pos_q - start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= 1'b1;
      start_q  <= START_RST;
      step_q   <= STEP_RST;
      pos_q    <= '0;
      gvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ENABLE: begin
            en_q     <= cfg_data_i[0];
            gvalid_q <= 1'b0;
          end
          CFG_START: begin
            start_q  <= cfg_data_i[POS_W-1:0];
            gvalid_q <= 1'b0;
          end
          CFG_STEP: begin
            step_q   <= cfg_data_i[STEP_W-1:0];
            gvalid_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        unique case (req_type_i)
          REQ_SAMPLE:  pos_q <= pos_q + POS_W'(1);
          REQ_SKIP:    pos_q <= pos_q + POS_W'(skip_count_i);
          REQ_RESTART: begin
            pos_q    <= '0;
            gvalid_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.gain_load) begin
        gvalid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && req_type_i == REQ_SAMPLE) begin
      smp_q  <= sample_in_i;
      fade_q <= en_q && (pos_q > start_q);
      k_q    <= diff[POS_W-1:BLOCK_SHIFT];
    end
    if (cmd_i.gain_load) begin
      gk_q   <= k_q;
      gain_q <= gain_d;
    end
  end

  // one restoring divide step per cycle
  assign rem_sh = {rem_q, q_q[QW-1]};
  assign ge     = rem_sh >= {1'b0, step_eff};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      q_q   <= {k_q, FRAC_BITS'(0)};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      q_q   <= {q_q[QW-2:0], ge};
      rem_q <= ge ? STEP_W'(rem_sh - {1'b0, step_eff}) : rem_sh[STEP_W-1:0];
    end
  end

  assign shift_s = q_q[QW-1:FRAC_BITS];
  assign frac_f  = q_q[FRAC_BITS-1:0];
  assign g_lin   = (UNITY_GAIN - GW'(frac_f)) + GW'(frac_f >> 1);
  assign gain_d  = (shift_s >= KW'(DEEP_SHIFT)) ? '0 : (g_lin >> shift_s[SHIFT_W-1:0]);

  // apply gain; arithmetic shift rounds toward minus infinity
  assign gain_sel = fade_q ? gain_q : UNITY_GAIN;
  assign prod     = smp_q * $signed({1'b0, gain_sel});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= prod[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  assign sts_o.fade     = fade_q;
  assign sts_o.hit      = gvalid_q && (gk_q == k_q);
  assign sts_o.div_last = (cnt_q == CNT_W'(QW - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

### rtl/alf_checker.sv
`include "audio_log_fade_out_defines.svh"

module alf_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic [alf_pkg::REQ_W-1:0]           req_type_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [alf_pkg::SAMPLE_W-1:0] sample_out_i
);
  import alf_pkg::*;

  // stalled output word holds
  `ALF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_out_i))

  // a sample word keeps the input side busy for the next cycle
  `ALF_ASSERT(a_sample_busy, clk_i, rst_ni, in_valid_i && in_ready_i && req_type_i == REQ_SAMPLE |=> !in_ready_i)

  // other words finish at once
  `ALF_ASSERT(a_other_free, clk_i, rst_ni, in_valid_i && in_ready_i && req_type_i != REQ_SAMPLE |=> in_ready_i)

  // a new result is loaded only from a cycle with a sample word in work
  `ALF_ASSERT(a_out_busy, clk_i, rst_ni, $rose(out_valid_i) |-> $past(!in_ready_i))

endmodule

bind audio_log_fade_out alf_checker u_alf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .req_type_i   (in_if.req_type),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .sample_out_i (out_if.sample_out)
);

### tb/fade_gain_checker.sv
module fade_gain_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [alf_pkg::REQ_W-1:0]      req_type_i,
  input  logic [alf_pkg::SAMPLE_W-1:0]   sample_in_i,
  input  logic [alf_pkg::SKIP_W-1:0]     skip_count_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [alf_pkg::SAMPLE_W-1:0]   sample_out_i,
  input  logic                           cfg_we_i,
  input  logic [alf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [alf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    pending_o,
  output int unsigned                    mismatch_o
);
  import alf_pkg::*;

  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic [SAMPLE_W-1:0] sample_in;
    logic [POS_W-1:0]    pos;
  } faded_word_t;

  faded_word_t faded_q[$];

  logic              fade_en_q;
  logic [POS_W-1:0]  fade_start_q;
  logic [STEP_W-1:0] fade_step_q;
  logic [POS_W-1:0]  pos_q;
  logic [POS_W-1:0]  gain_blk_q;
  logic [GW-1:0]     gain_q;

  task automatic report_mismatch(input string msg);
    if (mismatch_o < MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_o++;
  endtask

  // Advance the fade state by one accepted word; queue each sample word's result.
  task automatic predict_word(input logic [REQ_W-1:0] req, input logic [SAMPLE_W-1:0] smp,
                              input logic [SKIP_W-1:0] skp);
    faded_word_t        w;
    logic [POS_W-1:0]   k;
    logic [POS_W-1:0]   div;
    logic [POS_W-1:0]   halvings;
    logic [POS_W-1:0]   rem;
    logic [63:0]        frac;
    logic [63:0]        g;
    logic signed [31:0] x;
    logic signed [31:0] gs;
    logic signed [31:0] prod;
    logic [SAMPLE_W-1:0] res;
    case (req)
      REQ_SAMPLE: begin
        res = smp;
        if (fade_en_q && pos_q > fade_start_q) begin
          k = (pos_q - fade_start_q) >> BLOCK_SHIFT;
          if (k != gain_blk_q) begin
            gain_blk_q = k;
            div = (fade_step_q == '0) ? POS_W'(1) : POS_W'(fade_step_q);
            halvings = k / div;
            rem = k - halvings * div;
            frac = (64'(rem) << FRAC_BITS) / 64'(div);
            if (halvings >= POS_W'(DEEP_SHIFT)) begin
              gain_q = '0;
            end else begin
              g = (64'(UNITY_GAIN) - frac) + (frac >> 1);
              gain_q = GW'(g >> halvings);
            end
          end
          x = $signed(smp);
          gs = 32'(gain_q);
          // arithmetic shift floors toward minus infinity
          prod = (x * gs) >>> FRAC_BITS;
          res = prod[SAMPLE_W-1:0];
        end
        w.sample_out = res;
        w.sample_in = smp;
        w.pos = pos_q;
        faded_q.push_back(w);
        pos_q = pos_q + POS_W'(1);
      end
      REQ_SKIP: pos_q = pos_q + POS_W'(skp);
      REQ_RESTART: begin
        pos_q = '0;
        gain_blk_q = '1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_en_q = 1'b1;
      fade_start_q = START_RST;
      fade_step_q = STEP_RST;
      pos_q = '0;
      gain_blk_q = '1;
      gain_q = UNITY_GAIN;
      mismatch_o = 0;
      faded_q.delete();
    end else begin : watch
      faded_word_t exp_w;
      // output first: a word accepted now cannot leave on the same edge
      if (out_valid_i && out_ready_i) begin
        if (faded_q.size() == 0) begin
          report_mismatch($sformatf("output word %0d with nothing expected",
                                    $signed(sample_out_i)));
        end else begin
          exp_w = faded_q.pop_front();
          if (sample_out_i !== exp_w.sample_out)
            report_mismatch($sformatf("pos %0h in %0d: sample_out %0d, want %0d",
                                      exp_w.pos, $signed(exp_w.sample_in),
                                      $signed(sample_out_i), $signed(exp_w.sample_out)));
        end
      end
      if (in_valid_i && in_ready_i) predict_word(req_type_i, sample_in_i, skip_count_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLE: begin
            fade_en_q = cfg_data_i[0];
            gain_blk_q = '1;
          end
          CFG_START: begin
            fade_start_q = cfg_data_i[POS_W-1:0];
            gain_blk_q = '1;
          end
          CFG_STEP: begin
            fade_step_q = cfg_data_i[STEP_W-1:0];
            gain_blk_q = '1;
          end
          default: ;
        endcase
      end
    end
    pending_o <= faded_q.size();
  end

endmodule

### tb/tb_audio_log_fade_out.sv
module tb_audio_log_fade_out;
  import alf_pkg::*;

  localparam int     CLK_PERIOD   = 20;
  localparam int     RST_CYCLES   = 11;
  localparam int     DRAIN_CYCLES = 64;
  localparam int     PHASE_WORDS  = 100;
  localparam int     N_PHASES     = 9;
  localparam longint TIMEOUT      = 64'd50_000_000;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    tight_tx;
  int unsigned           pending;
  int unsigned           mismatches;

  alf_in_if  in_ch ();
  alf_out_if out_ch ();

  audio_log_fade_out u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  fade_gain_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .req_type_i   (in_ch.req_type),
    .sample_in_i  (in_ch.sample_in),
    .skip_count_i (in_ch.skip_count),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .sample_out_i (out_ch.sample_out),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (pending),
    .mismatch_o   (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT);
    $display("Simulation FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit tight);
    int r;
    if (tight) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      3:       return 16'h0001;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [SKIP_W-1:0] pick_skip();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SKIP_W'($urandom_range(0, 15));
      4:          return SKIP_W'($urandom_range(511, 513));
      5, 6, 7:    return SKIP_W'($urandom);
      default:    return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] random_start();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return POS_W'($urandom_range(0, 4096));
      2:       return POS_W'($urandom);
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [STEP_W-1:0] random_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'd1;
      2:       return STEP_W'($urandom_range(2, 16));
      3:       return STEP_W'($urandom_range(17, 400));
      4:       return 16'hFFFF;
      default: return STEP_W'($urandom);
    endcase
  endfunction

  task automatic push_word(input logic [REQ_W-1:0] req, input logic [SAMPLE_W-1:0] smp,
                           input logic [SKIP_W-1:0] skp);
    int gap;
    gap = pick_gap(tight_tx);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.sample_in  <= smp;
    in_ch.skip_count <= skp;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // skip and restart words give no output, so wait out the divider as well
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic load_regs(input logic en, input logic [POS_W-1:0] start,
                           input logic [STEP_W-1:0] step);
    settle();
    put_reg(CFG_ENABLE, CFG_DATA_W'(en));
    put_reg(CFG_START, CFG_DATA_W'(start));
    put_reg(CFG_STEP, CFG_DATA_W'(step));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int hold;
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int n;
    int r;
    logic [REQ_W-1:0]  req;
    logic [SKIP_W-1:0] skp;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= CFG_ENABLE;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_SAMPLE;
    in_ch.sample_in  <= '0;
    in_ch.skip_count <= '0;
    tight_tx = 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: position stays below the fade start, words pass unchanged
    push_word(REQ_SAMPLE, 16'h7FFF, 16'h0000);
    push_word(REQ_SAMPLE, 16'h8000, 16'hFFFF);
    push_word(REQ_SAMPLE, 16'h0000, 16'h0000);
    push_word(REQ_SAMPLE, 16'hFFFF, 16'hFFFF);
    push_word(REQ_UNUSED, 16'h1234, 16'h4321);
    push_word(REQ_SKIP, 16'hFFFF, 16'h0000);
    push_word(REQ_SKIP, 16'h0000, 16'hFFFF);
    push_word(REQ_SAMPLE, 16'h5A5A, 16'h0000);
    push_word(REQ_RESTART, 16'h0000, 16'hFFFF);
    push_word(REQ_SAMPLE, 16'hA5A5, 16'h0000);

    // zero step acts as one: halving per block, start at one
    load_regs(1'b1, 32'd1, 16'd0);
    push_word(REQ_SAMPLE, 16'h7FFF, 16'h0000);  // position equal to start
    push_word(REQ_SAMPLE, 16'h8000, 16'h0000);  // unity gain
    push_word(REQ_SKIP, 16'h0000, 16'd510);
    push_word(REQ_SAMPLE, 16'h8000, 16'h0000);  // one halving
    push_word(REQ_SAMPLE, 16'h7FFF, 16'h0000);
    push_word(REQ_SKIP, 16'h0000, 16'd6654);
    push_word(REQ_SAMPLE, 16'hFFFF, 16'h0000);  // gain of one, floors to -1
    push_word(REQ_SAMPLE, 16'h7FFF, 16'h0000);
    push_word(REQ_SKIP, 16'h0000, 16'd510);
    push_word(REQ_SAMPLE, 16'h8000, 16'h0000);  // deep fade, zero gain
    push_word(REQ_SAMPLE, 16'h7FFF, 16'h0000);
    push_word(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
    push_word(REQ_RESTART, 16'hFFFF, 16'h0000);
    push_word(REQ_SAMPLE, 16'h0064, 16'h0000);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       load_regs(1'b1, 32'd0, 16'd1);
        1:       load_regs(1'b1, POS_W'($urandom_range(0, 2000)), STEP_W'($urandom_range(2, 12)));
        2:       load_regs(1'b0, 32'd0, 16'd3);
        3:       load_regs(1'b1, 32'd0, 16'hFFFF);
        4:       load_regs(1'b1, 32'hFFFF_FFFF, random_step());
        5:       load_regs(1'b1, POS_W'($urandom_range(0, 100000)), 16'd0);
        default: load_regs($urandom_range(0, 3) != 0, random_start(), random_step());
      endcase
      tight_tx = ($urandom_range(0, 3) == 0);
      push_word(REQ_RESTART, random_sample(), SKIP_W'($urandom));
      n = 0;
      while (n < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        skp = SKIP_W'($urandom);
        if (r < 68) begin
          req = REQ_SAMPLE;
        end else if (r < 88) begin
          req = REQ_SKIP;
          skp = pick_skip();
        end else if (r < 94) begin
          req = REQ_RESTART;
        end else begin
          req = REQ_UNUSED;
        end
        push_word(req, random_sample(), skp);
        if (req != REQ_UNUSED) n++;
      end
    end
    tight_tx = 1'b0;

    settle();
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
